[src/rcb_pkg.sv]
// Shared types, constants and pixel helper functions of the RGB565 crossfade blender.
package rcb_pkg;

   // Default raster geometry.
   localparam int SCREEN_WIDTH_DEFAULT  = 800;
   localparam int SCREEN_HEIGHT_DEFAULT = 480;

   // Blend arithmetic constants.
   localparam logic [31:0] FIELD_MASK  = 32'h07E0_F81F;
   localparam logic [5:0]  FULL_LEVEL  = 6'd32;
   localparam int          LEVEL_SHIFT = 5;
   localparam int          HALF_SHIFT  = 16;

   // Field and internal widths.
   localparam int PIXEL_W     = 16;
   localparam int ADDR_W      = 19;
   localparam int LEVEL_W     = 6;
   localparam int LOGO_W_W    = 10;
   localparam int LOGO_H_W    = 9;
   localparam int COORD_W     = 11;
   localparam int GEO_W       = 12;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL       = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOGO_WIDTH  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOGO_HEIGHT = 4'd3;

   typedef struct packed {
      logic [PIXEL_W-1:0] logo_pixel;
      logic [PIXEL_W-1:0] dash_pixel;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic [ADDR_W-1:0]  fb_address;
      logic               frame_last;
   } rsp_type;

   // Decoded configuration, held ready for the front and back ends.
   typedef struct packed {
      logic               mode;
      logic [LEVEL_W-1:0] level;
      logic [GEO_W-1:0]   logo_w;
      logic [GEO_W-1:0]   logo_h;
      logic [GEO_W-1:0]   origin_x;
      logic [GEO_W-1:0]   origin_y;
      logic [GEO_W-1:0]   end_x;
      logic [GEO_W-1:0]   end_y;
   } cfg_type;

   // One classified item waiting for the blend unit.
   typedef struct packed {
      logic [PIXEL_W-1:0] base_pixel;
      logic [PIXEL_W-1:0] target_pixel;
      logic               pass_raw;
      logic [COORD_W-1:0] screen_row;
      logic [COORD_W-1:0] screen_col;
      logic               frame_last;
   } work_type;

   function automatic logic [31:0] widen565(input logic [PIXEL_W-1:0] c);
      return ({16'h0000, c} | {c, 16'h0000}) & FIELD_MASK;
   endfunction

   function automatic logic [PIXEL_W-1:0] narrow565(input logic [31:0] x);
      return x[15:0] | x[31:16];
   endfunction

endpackage

[src/rcb_csr.sv]
// Configuration registers and the derived logo geometry.
module rcb_csr #(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rcb_pkg::cfg_type               cfg
);
   import rcb_pkg::*;

   localparam logic [GEO_W-1:0] SW_G = GEO_W'(SCREEN_WIDTH);
   localparam logic [GEO_W-1:0] SH_G = GEO_W'(SCREEN_HEIGHT);
   localparam logic [GEO_W-1:0] OX_RESET = GEO_W'((SCREEN_WIDTH - 1) / 2);
   localparam logic [GEO_W-1:0] OY_RESET = GEO_W'((SCREEN_HEIGHT - 1) / 2);

   function automatic logic [GEO_W-1:0] fit_size(input logic [GEO_W-1:0] v,
                                                 input logic [GEO_W-1:0] limit);
      if (v == '0) begin
         return GEO_W'(1);
      end
      return (v > limit) ? limit : v;
   endfunction

   cfg_type cfg_ff, cfg_in;
   logic [GEO_W-1:0] new_w, new_h;

   assign csr_ready = 1'b1;

   // Size the logo and place it at write time, so geometry is ready at once.
   always_comb begin
      new_w  = fit_size(GEO_W'(csr_wdata[LOGO_W_W-1:0]), SW_G);
      new_h  = fit_size(GEO_W'(csr_wdata[LOGO_H_W-1:0]), SH_G);
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE: begin
               cfg_in.mode = csr_wdata[0];
            end
            CSR_LEVEL: begin
               cfg_in.level = csr_wdata[LEVEL_W-1:0];
            end
            CSR_LOGO_WIDTH: begin
               cfg_in.logo_w   = new_w;
               cfg_in.origin_x = (SW_G - new_w) >> 1;
               cfg_in.end_x    = ((SW_G - new_w) >> 1) + new_w;
            end
            CSR_LOGO_HEIGHT: begin
               cfg_in.logo_h   = new_h;
               cfg_in.origin_y = (SH_G - new_h) >> 1;
               cfg_in.end_y    = ((SH_G - new_h) >> 1) + new_h;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= 1'b1;
         cfg_ff.level    <= FULL_LEVEL;
         cfg_ff.logo_w   <= GEO_W'(1);
         cfg_ff.logo_h   <= GEO_W'(1);
         cfg_ff.origin_x <= OX_RESET;
         cfg_ff.origin_y <= OY_RESET;
         cfg_ff.end_x    <= OX_RESET + GEO_W'(1);
         cfg_ff.end_y    <= OY_RESET + GEO_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/rcb_front.sv]
// Raster position counters and classification of each accepted pixel.
module rcb_front #(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic              clock,
   input  logic              reset,
   input  rcb_pkg::cfg_type  cfg,
   input  logic              req_push,
   input  rcb_pkg::req_type  req_data,
   input  logic              queue_full,
   output logic              queue_push,
   output rcb_pkg::work_type work
);
   import rcb_pkg::*;

   localparam int COL_W = $clog2(SCREEN_WIDTH);
   localparam int ROW_W = $clog2(SCREEN_HEIGHT);

   logic [COL_W-1:0] col_cnt_ff, col_cnt_in, col_base, col;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in, row_base, row;
   logic [GEO_W-1:0] span_w, span_h, col_g, row_g, col_plus, row_plus;
   logic             in_logo, col_wrap, row_wrap;

   assign queue_push = req_push && !queue_full;

   always_comb begin
      span_w   = cfg.mode ? GEO_W'(SCREEN_WIDTH) : cfg.logo_w;
      span_h   = cfg.mode ? GEO_W'(SCREEN_HEIGHT) : cfg.logo_h;
      col_base = req_data.frame_start ? '0 : col_cnt_ff;
      row_base = req_data.frame_start ? '0 : row_cnt_ff;
      // A counter left beyond the raster by a mode or size change restarts at zero.
      col      = (GEO_W'(col_base) >= span_w) ? '0 : col_base;
      row      = (GEO_W'(row_base) >= span_h) ? '0 : row_base;
      col_g    = GEO_W'(col);
      row_g    = GEO_W'(row);
      col_plus = col_g + GEO_W'(1);
      row_plus = row_g + GEO_W'(1);
      col_wrap = col_plus >= span_w;
      row_wrap = row_plus >= span_h;
      in_logo  = (row_g >= cfg.origin_y) && (row_g < cfg.end_y) &&
                 (col_g >= cfg.origin_x) && (col_g < cfg.end_x);

      if (cfg.mode) begin
         work.base_pixel = in_logo ? req_data.logo_pixel : '0;
         work.target_pixel = req_data.dash_pixel;
         work.pass_raw   = 1'b0;
         work.screen_row = COORD_W'(row_g);
         work.screen_col = COORD_W'(col_g);
      end else begin
         work.base_pixel = '0;
         work.target_pixel = req_data.logo_pixel;
         work.pass_raw   = cfg.level >= FULL_LEVEL;
         work.screen_row = COORD_W'(cfg.origin_y + row_g);
         work.screen_col = COORD_W'(cfg.origin_x + col_g);
      end
      work.frame_last = col_wrap && row_wrap;

      col_cnt_in = col_wrap ? '0 : col_plus[COL_W-1:0];
      if (col_wrap) begin
         row_cnt_in = row_wrap ? '0 : row_plus[ROW_W-1:0];
      end else begin
         row_cnt_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (queue_push) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

endmodule

[src/rcb_queue.sv]
// Small first-in first-out queue between the front and back ends.
module rcb_queue #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

[src/rcb_back.sv]
// Blend unit: multiply stage, then add, mask and pack into the result register.
module rcb_back #(
   parameter int SCREEN_WIDTH = 800
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rcb_pkg::LEVEL_W-1:0] level,
   input  logic                        queue_empty,
   input  rcb_pkg::work_type           work,
   output logic                        queue_pop,
   output rcb_pkg::rsp_type            rsp_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop
);
   import rcb_pkg::*;

   logic               s1_valid_ff, out_valid_ff;
   logic [31:0]        prod_ff, prod_in, base_ff, base_in, addr_full;
   logic               pass_ff, last_ff;
   logic [PIXEL_W-1:0] raw_ff;
   logic [ADDR_W-1:0]  addr_ff;
   rsp_type            out_ff, out_in;
   logic               out_move, s1_move;

   assign out_move  = !out_valid_ff || rsp_pop;
   assign s1_move   = !s1_valid_ff || out_move;
   assign queue_pop = s1_move && !queue_empty;

   always_comb begin
      base_in   = widen565(work.base_pixel);
      prod_in   = (widen565(work.target_pixel) - base_in) * 32'(level);
      addr_full = 32'(work.screen_row) * 32'(SCREEN_WIDTH) + 32'(work.screen_col);

      out_in.pixel_out  = pass_ff ? raw_ff :
                          narrow565((base_ff + (prod_ff >> LEVEL_SHIFT)) & FIELD_MASK);
      out_in.fb_address = addr_ff;
      out_in.frame_last = last_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
         pass_ff <= work.pass_raw;
         raw_ff  <= work.target_pixel;
         addr_ff <= addr_full[ADDR_W-1:0];
         last_ff <= work.frame_last;
      end
      if (out_move) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            s1_valid_ff <= !queue_empty;
         end
         if (out_move) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

[src/rgb565_crossfade_blender_top.sv]
// Top level of the RGB565 crossfade blender.
//
// Pixels arrive in raster order on a queue-style input: an item is taken at a
// rising edge with req_push high and req_full low. Each item yields exactly one
// result item on rsp_data, shown while rsp_empty is low and taken at an edge
// with rsp_pop high. The result carries the blended pixel, its frame-buffer
// address and a mark on the last pixel of the frame or logo.
// Configuration uses its own valid/ready write port; csr_ready is always high,
// and registers are meant to be written only while no items are in flight.
// An accepted item passes the queue, the multiply stage and the result
// register. While results are taken, one item per cycle is sustained: the
// front end classifies an item as it is accepted, a four-entry queue holds the
// classified items, and the back end runs one blend multiply per item.
// When the receiver stalls, the result register holds, the back end stops and
// the queue fills; req_full rises once four items are queued.
// Synchronous reset empties all stages, zeroes the raster counters and loads
// crossfade mode, full level and a one-by-one logo.
module rgb565_crossfade_blender_top #(
   parameter int SCREEN_WIDTH  = rcb_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = rcb_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  rcb_pkg::req_type                req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output rcb_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rcb_pkg::*;

   cfg_type  cfg;
   work_type front_work, back_work;
   logic     queue_push, queue_full, queue_pop, queue_empty;

   // Register file with the logo geometry derived as each size is written.
   rcb_csr #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   // The front end owns the raster counters and decides inside or outside.
   rcb_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_push  (req_push),
      .req_data  (req_data),
      .queue_full(queue_full),
      .queue_push(queue_push),
      .work      (front_work)
   );

   // The input side is full exactly when the middle queue is full.
   assign req_full = queue_full;

   rcb_queue #(
      .DEPTH(QUEUE_DEPTH),
      .WIDTH($bits(work_type))
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_data(front_work),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_data (back_work),
      .empty    (queue_empty)
   );

   // The back end does the blend arithmetic and the address multiply.
   rcb_back #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .level      (cfg.level),
      .queue_empty(queue_empty),
      .work       (back_work),
      .queue_pop  (queue_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule

[src/rcb_checker.sv]
// Port-level checks of the blender, bound to its top level.
module rcb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input rcb_pkg::rsp_type rsp_data
);
   import rcb_pkg::*;

   // Reset leaves no item behind and room for new ones.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("blender not empty after reset");

   // A waiting result that is not taken stays on the ports unchanged.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled result changed");

   // Some result must be waiting once an accepted item has gone through.
   assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> ##2 !rsp_empty)
      else $error("accepted item did not reach the result ports");

   // The input side can only fill up while results are held back.
   assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input full with no result waiting");

endmodule

bind rgb565_crossfade_blender_top rcb_checker u_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps

// Testbench for the RGB565 crossfade blender: predicts and checks every pixel.
module tb;
   import rcb_pkg::*;

   // Screen geometry of the instance under test.
   localparam int SCR_W = SCREEN_WIDTH_DEFAULT;
   localparam int SCR_H = SCREEN_HEIGHT_DEFAULT;

   // The limit leaves a wide margin over the slowest correct run.
   localparam int CYCLE_LIMIT = 200000;

   // This tail is far more than enough for a stray result to show up after the
   // last expected one.
   localparam int TAIL_CYCLES = 20;

   // Every input of the block holds a known value from time zero.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   req_type req_data  = '0;
   logic    rsp_pop   = 1'b0;
   logic    csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic    req_full;
   logic    rsp_empty;
   logic    csr_ready;
   rsp_type rsp_data;

   // Predictor copy of the configuration registers, at their reset values.
   logic                fade_mode  = 1'b1;
   logic [LEVEL_W-1:0]  fade_level = FULL_LEVEL;
   logic [LOGO_W_W-1:0] logo_w_reg = LOGO_W_W'(1);
   logic [LOGO_H_W-1:0] logo_h_reg = LOGO_H_W'(1);

   // Predictor copy of the raster position counters.
   int raster_col = 0;
   int raster_row = 0;

   // Pixels that the block still owes us, oldest first.
   rsp_type pending_pixels[$];
   rsp_type want_pixel;

   // Idle percentages of the sender and the receiver for the current phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   int unsigned items_sent  = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   always #5 clock = ~clock;

   rgb565_crossfade_blender_top #(
      .SCREEN_WIDTH  (SCR_W),
      .SCREEN_HEIGHT (SCR_H)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Pixel arithmetic. A pixel is spread so that red, green and blue sit in
   // separate lanes of a 32-bit word with room above each of them; one
   // multiply then scales all three at once. All sums wrap at 32 bits.
   // ------------------------------------------------------------------------
   function automatic logic [31:0] spread565(input logic [15:0] c);
      logic [31:0] w;
      w = {16'h0000, c};
      return (w | (w << HALF_SHIFT)) & FIELD_MASK;
   endfunction

   function automatic logic [15:0] pack565(input logic [31:0] x);
      return x[15:0] | x[31:16];
   endfunction

   // Mix from pixel a toward pixel b by lvl/32.
   function automatic logic [15:0] mix565(input logic [15:0] a, input logic [15:0] b,
                                          input logic [31:0] lvl);
      logic [31:0] xa;
      logic [31:0] xb;
      logic [31:0] step;
      xa   = spread565(a);
      xb   = spread565(b);
      step = ((xb - xa) * lvl) >> LEVEL_SHIFT;
      return pack565((xa + step) & FIELD_MASK);
   endfunction

   // Scale a pixel up from black by lvl/32.
   function automatic logic [15:0] dim565(input logic [15:0] c, input logic [31:0] lvl);
      logic [31:0] prod;
      prod = spread565(c) * lvl;
      return pack565((prod >> LEVEL_SHIFT) & FIELD_MASK);
   endfunction

   // A logo size of zero counts as one; anything past the screen is clipped.
   function automatic int clamp_size(input int v, input int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // Works out the pixel, address and end-of-frame mark for one accepted item
   // and advances the raster counters the way the block does.
   function automatic rsp_type predict_pixel(input req_type item);
      int          lw;
      int          lh;
      int          ox;
      int          oy;
      int          span_w;
      int          span_h;
      int          col;
      int          row;
      logic        in_logo;
      logic [31:0] addr;
      rsp_type     r;
      lw     = clamp_size(int'(logo_w_reg), SCR_W);
      lh     = clamp_size(int'(logo_h_reg), SCR_H);
      ox     = (SCR_W - lw) / 2;
      oy     = (SCR_H - lh) / 2;
      span_w = fade_mode ? SCR_W : lw;
      span_h = fade_mode ? SCR_H : lh;
      if (item.frame_start) begin
         raster_col = 0;
         raster_row = 0;
      end
      // A mode or size change can leave the counters outside the new raster.
      if (raster_col >= span_w) raster_col = 0;
      if (raster_row >= span_h) raster_row = 0;
      col = raster_col;
      row = raster_row;
      if (fade_mode) begin
         in_logo = (row >= oy) && (row < oy + lh) && (col >= ox) && (col < ox + lw);
         r.pixel_out = in_logo ? mix565(item.logo_pixel, item.dash_pixel, 32'(fade_level))
                               : dim565(item.dash_pixel, 32'(fade_level));
         addr = row * SCR_W + col;
      end else begin
         // At full level and above the logo passes through untouched.
         r.pixel_out = (fade_level >= FULL_LEVEL) ? item.logo_pixel
                                                  : dim565(item.logo_pixel, 32'(fade_level));
         addr = (oy + row) * SCR_W + ox + col;
      end
      r.fb_address = addr[ADDR_W-1:0];
      r.frame_last = (col + 1 == span_w) && (row + 1 == span_h);
      if (col + 1 >= span_w) begin
         raster_col = 0;
         raster_row = (row + 1 >= span_h) ? 0 : row + 1;
      end else begin
         raster_col = col + 1;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Mostly random colors, with black and white now and then.
   function automatic logic [15:0] random_color();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Levels cluster on black and full, since those are the interesting ends.
   function automatic int unsigned random_level();
      case ($urandom_range(3))
         0: return 0;
         1: return 32'(FULL_LEVEL);
         default: return $urandom_range(63);
      endcase
   endfunction

   function automatic req_type pixel_item(input logic [15:0] logo, input logic [15:0] dash,
                                          input logic start);
      req_type t;
      t.logo_pixel  = logo;
      t.dash_pixel  = dash;
      t.frame_start = start;
      return t;
   endfunction

   // Sends one item: random idle cycles first, then push is held until the
   // block takes the item. The expectation is queued before acceptance, which
   // is safe because the result must still pass the queue and the back end.
   task automatic push_pixel(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      pending_pixels.push_back(predict_pixel(item));
      items_sent++;
      do @(posedge clock); while (req_full);
   endtask

   // Stops sending and waits until every owed pixel has come back. It always
   // waits on the clock first, so push is never lowered and raised in one step.
   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // Register writes happen only with the pipeline empty.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:        fade_mode  = value[0];
         CSR_LEVEL:       fade_level = value[LEVEL_W-1:0];
         CSR_LOGO_WIDTH:  logo_w_reg = value[LOGO_W_W-1:0];
         CSR_LOGO_HEIGHT: logo_h_reg = value[LOGO_H_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input bit m, input int unsigned lvl,
                                input int unsigned w, input int unsigned h);
      write_reg(CSR_MODE, 32'(m));
      write_reg(CSR_LEVEL, lvl);
      write_reg(CSR_LOGO_WIDTH, w);
      write_reg(CSR_LOGO_HEIGHT, h);
   endtask

   // Streams random pixels. The first one may restart the frame; later ones
   // restart it with the given percentage, which models a glitchy source.
   task automatic stream_pixels(input int count, input bit start_first, input int start_pct);
      bit start;
      for (int i = 0; i < count; i++) begin
         start = (i == 0) ? start_first : ($urandom_range(99) < start_pct);
         push_pixel(pixel_item(random_color(), random_color(), start));
      end
   endtask

   // A one-pixel-wide logo makes the row advance on every item, so the raster
   // can be parked on any row cheaply before switching to crossfade.
   task automatic park_on_row(input int rows, input int unsigned lvl);
      apply_setting(1'b0, lvl, 1, SCR_H);
      stream_pixels(rows, 1'b1, 0);
   endtask

   // ------------------------------------------------------------------------
   // Result side: random back-pressure and the in-order comparison.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: pixel %h address %0d last %b",
                        rsp_data.pixel_out, rsp_data.fb_address, rsp_data.frame_last);
         end else begin
            want_pixel = pending_pixels.pop_front();
            if (rsp_data.pixel_out !== want_pixel.pixel_out ||
                rsp_data.fb_address !== want_pixel.fb_address ||
                rsp_data.frame_last !== want_pixel.frame_last) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch (expected/actual): pixel %h/%h address %0d/%0d last %b/%b",
                           want_pixel.pixel_out, rsp_data.pixel_out,
                           want_pixel.fb_address, rsp_data.fb_address,
                           want_pixel.frame_last, rsp_data.frame_last);
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Straight out of reset the block crossfades at full level with a 1x1 logo
   // in the middle, so the top-left pixels are plain dashboard pixels.
   task automatic test_reset_state();
      push_pixel(pixel_item(16'h0000, 16'hFFFF, 1'b1));
      push_pixel(pixel_item(16'hFFFF, 16'h0000, 1'b0));
      push_pixel(pixel_item(16'hF800, 16'h07E0, 1'b0));
   endtask

   // Logo mode with a 3x2 logo: one full frame of pure channel extremes at full
   // level, then a level above full (still a pass-through), black and a
   // partial level.
   task automatic test_logo_levels();
      apply_setting(1'b0, 32'(FULL_LEVEL), 3, 2);
      push_pixel(pixel_item(16'h0000, 16'hFFFF, 1'b1));
      push_pixel(pixel_item(16'hFFFF, 16'h0000, 1'b0));
      push_pixel(pixel_item(16'hF800, 16'h001F, 1'b0));
      push_pixel(pixel_item(16'h07E0, 16'hF800, 1'b0));
      push_pixel(pixel_item(16'h001F, 16'h07E0, 1'b0));
      push_pixel(pixel_item(16'hFFFF, 16'hFFFF, 1'b0));
      write_reg(CSR_LEVEL, 63);
      stream_pixels(2, 1'b1, 0);
      write_reg(CSR_LEVEL, 0);
      stream_pixels(2, 1'b0, 0);
      write_reg(CSR_LEVEL, 17);
      stream_pixels(1, 1'b0, 0);
   endtask

   // Zero sizes count as one, oversize logos are clipped to the screen, and a
   // counter left beyond a shrunken raster restarts at zero.
   task automatic test_size_limits();
      apply_setting(1'b0, 9, 0, 0);
      stream_pixels(1, 1'b0, 0);
      apply_setting(1'b0, 40, 1023, 511);
      stream_pixels(2, 1'b1, 0);
      apply_setting(1'b0, 25, 5, 1);
      stream_pixels(3, 1'b1, 0);
      write_reg(CSR_LOGO_WIDTH, 2);
      stream_pixels(1, 1'b0, 0);
   endtask

   // Crossfade with a logo that covers the whole screen, at black and at
   // levels above full, where the lane arithmetic wraps.
   task automatic test_crossfade_levels();
      apply_setting(1'b1, 0, 1023, SCR_H);
      push_pixel(pixel_item(16'hFFFF, 16'h0000, 1'b1));
      write_reg(CSR_LEVEL, 33);
      push_pixel(pixel_item(16'h0000, 16'hFFFF, 1'b0));
      write_reg(CSR_LEVEL, 63);
      push_pixel(pixel_item(16'hFFFF, 16'h0000, 1'b0));
   endtask

   // Random mix of segments: logo-mode frames, crossfades that start just
   // above a near-screen-size logo so its top and left edges are crossed, and
   // noise with arbitrary settings and stray frame starts.
   task automatic test_random_mix(input int unsigned budget);
      int unsigned first;
      int          kind;
      int          w;
      int          h;
      int          n;
      int          lh;
      int          oy;
      int          rows;
      first = items_sent;
      while (items_sent - first < budget) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(12);
            h = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(8);
            apply_setting(1'b0, random_level(), w, h);
            n = clamp_size(w, SCR_W) * clamp_size(h, SCR_H) * $urandom_range(1, 2);
            if (n > 60) n = $urandom_range(1, 60);
            stream_pixels(n, $urandom_range(9) != 0, 3);
         end else if (kind < 85) begin
            lh   = SCR_H - $urandom_range(13);
            oy   = (SCR_H - lh) / 2;
            rows = $urandom_range(oy + 1);
            park_on_row(rows, random_level());
            apply_setting(1'b1, random_level(), SCR_W - $urandom_range(17), lh);
            stream_pixels($urandom_range(10, 40), rows == 0, 3);
         end else begin
            apply_setting($urandom_range(1), random_level(), $urandom_range(1023),
                          $urandom_range(511));
            stream_pixels($urandom_range(5, 30), $urandom_range(1), 10);
         end
      end
   endtask

   // A full-width logo one row high sits on the middle row. The raster is
   // parked on that row and two crossfaded pixels land inside the logo. A
   // one-pixel-wide logo then steps the row once, so the next crossfaded
   // pixels lie just below the bottom edge of the logo.
   task automatic test_bottom_edge();
      park_on_row(SCR_H / 2 - 1, 32'(FULL_LEVEL));
      apply_setting(1'b1, random_level(), 1023, 1);
      stream_pixels(2, 1'b0, 0);
      apply_setting(1'b0, 32'(FULL_LEVEL), 1, SCR_H);
      stream_pixels(1, 1'b0, 0);
      apply_setting(1'b1, random_level(), 1023, 1);
      stream_pixels(2, 1'b0, 0);
   endtask

   initial begin
      // Reset is held at the start and never asserted again.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: sender idles now and then, receiver stalls most of the time.
      send_idle_pct = 31;
      recv_idle_pct = 71;
      test_reset_state();
      test_logo_levels();
      test_size_limits();
      test_crossfade_levels();
      test_random_mix(110);

      // Phase two: the other way round.
      send_idle_pct = 71;
      recv_idle_pct = 31;
      test_random_mix(110);

      // Phase three: full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_mix(110);
      test_bottom_edge();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
src/rcb_pkg.sv
src/rcb_csr.sv
src/rcb_front.sv
src/rcb_queue.sv
src/rcb_back.sv
src/rgb565_crossfade_blender_top.sv
src/rcb_checker.sv
tb/tb.sv
